/* rtl/core/ttad_pkg.sv */
package ttad_pkg;

    // frame layout
    localparam int CHANNELS   = 2;
    localparam int CODE_BYTES = 16;
    localparam int POS_W      = $clog2(CODE_BYTES + 2);
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // predictor coefficients and sample limits
    localparam logic signed [16:0] COEF_PREV  = 17'sh07298;
    localparam logic signed [16:0] COEF_OLDER = 17'sh03350;
    localparam logic signed [22:0] SAMPLE_MAX = 23'sd32767;
    localparam logic signed [22:0] SAMPLE_MIN = -23'sd32768;

    // shared unit widths
    localparam int OPA_W  = 33;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 37;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic signed [OPA_W-1:0] op_a;
        logic signed [OPB_W-1:0] op_b;
        logic [1:0]              acc_op;
    } mac_cmd_t;

endpackage

/* rtl/core/two_tap_adpcm_frame_decoder.sv */
// Two-tap ADPCM frame decoder.
// Input words on s_*: s_tdata carries one frame byte, s_tuser its channel.
// Each frame is two big-endian scale bytes followed by code bytes,
// each code byte holding two signed 4-bit codes, high nibble first.
// Output words on m_*: m_tdata is the saturated 16-bit sample, m_tuser the
// channel, m_tlast marks the low-nibble sample of a byte's pair.
// cfg_we/cfg_wdata write the base gain (reset value 16384).
// Scale bytes are taken directly in the idle state and give no output.
// A code byte runs each nibble through one shared multiplier and accumulator:
// gain times scale, times code, previous tap, older tap, then shift and
// saturate, through the states SF, D, P, O, SUM and OUT for each sample;
// s_tready stays low until both samples of the byte are registered.
// The output register holds one sample; if the receiver stalls, the sequencer
// waits with the next sample until m_tready takes the held word.
// Reset (aresetn low, synchronous) clears the byte position, frame scale,
// both predictor histories and the output valid, and restores the gain.
module two_tap_adpcm_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample
    output logic        m_tuser,   // out_channel
    output logic        m_tlast    // last
);
    import ttad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SF   = 3'd1;
    localparam logic [2:0] ST_D    = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_O    = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]        state_reg;
    logic [15:0]       gain_reg;
    logic [15:0]       scale_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        byte_reg;
    logic              ch_reg;
    logic              nib_sel_reg;
    logic signed [15:0] prev_reg  [CHANNELS];
    logic signed [15:0] older_reg [CHANNELS];
    logic              out_valid_reg;
    logic [15:0]       out_sample_reg;
    logic              out_ch_reg;
    logic              out_last_reg;

    logic [CH_IDX_W-1:0]       ch_idx;
    logic                      in_ok;
    logic                      accept;
    logic [3:0]                nib;
    mac_cmd_t                  cmd;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;
    logic signed [22:0]        shifted;
    logic signed [15:0]        sat;
    logic                      out_free;

    assign ch_idx   = CH_IDX_W'(ch_reg);
    assign in_ok    = (32'(s_tuser) < CHANNELS);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign nib      = nib_sel_reg ? byte_reg[3:0] : byte_reg[7:4];

    // operand selection for the shared unit
    always_comb begin
        cmd.op_a   = '0;
        cmd.op_b   = '0;
        cmd.acc_op = ACC_HOLD;
        case (state_reg)
            ST_SF: begin
                cmd.op_a = OPA_W'($signed({1'b0, gain_reg}));
                cmd.op_b = OPB_W'($signed({1'b0, scale_reg}));
            end
            ST_D: begin
                cmd.op_a = $signed({1'b0, prod[31:0]});
                cmd.op_b = OPB_W'($signed(nib));
            end
            ST_P: begin
                cmd.op_a   = OPA_W'(prev_reg[ch_idx]);
                cmd.op_b   = COEF_PREV;
                cmd.acc_op = ACC_LOAD;
            end
            ST_O: begin
                cmd.op_a   = OPA_W'(older_reg[ch_idx]);
                cmd.op_b   = COEF_OLDER;
                cmd.acc_op = ACC_ADD;
            end
            ST_SUM: begin
                cmd.acc_op = ACC_SUB;
            end
            default: begin
                cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    ttad_mac u_mac (
        .aclk (aclk),
        .cmd  (cmd),
        .prod (prod),
        .acc  (acc)
    );

    // floor shift by 14 and saturate
    assign shifted = acc[ACC_W-1:14];
    always_comb begin
        if (shifted > SAMPLE_MAX) begin
            sat = 16'sh7fff;
        end else if (shifted < SAMPLE_MIN) begin
            sat = -16'sh8000;
        end else begin
            sat = shifted[15:0];
        end
    end

    // sequencer, frame state and predictor history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain_reg      <= 16'd16384;
            scale_reg     <= '0;
            pos_reg       <= '0;
            nib_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                prev_reg[i]  <= '0;
                older_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_wdata;
            end
            if (out_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && in_ok) begin
                        if (pos_reg == '0) begin
                            scale_reg[15:8] <= s_tdata;
                            pos_reg         <= POS_W'(1);
                        end else if (pos_reg == POS_W'(1)) begin
                            scale_reg[7:0] <= s_tdata;
                            pos_reg        <= POS_W'(2);
                        end else begin
                            byte_reg    <= s_tdata;
                            ch_reg      <= s_tuser;
                            nib_sel_reg <= 1'b0;
                            state_reg   <= ST_SF;
                        end
                    end
                end
                ST_SF:  state_reg <= ST_D;
                ST_D:   state_reg <= ST_P;
                ST_P:   state_reg <= ST_O;
                ST_O:   state_reg <= ST_SUM;
                ST_SUM: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        out_valid_reg     <= 1'b1;
                        out_sample_reg    <= sat;
                        out_ch_reg        <= ch_reg;
                        out_last_reg      <= nib_sel_reg;
                        older_reg[ch_idx] <= prev_reg[ch_idx];
                        prev_reg[ch_idx]  <= sat;
                        if (!nib_sel_reg) begin
                            nib_sel_reg <= 1'b1;
                            state_reg   <= ST_SF;
                        end else begin
                            state_reg <= ST_IDLE;
                            if (pos_reg >= POS_W'(CODE_BYTES + 1)) begin
                                pos_reg <= '0;
                            end else begin
                                pos_reg <= pos_reg + POS_W'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/ttad_mac.sv */
module ttad_mac (
    input  logic                          aclk,
    input  ttad_pkg::mac_cmd_t            cmd,
    output logic signed [ttad_pkg::PROD_W-1:0] prod,
    output logic signed [ttad_pkg::ACC_W-1:0]  acc
);
    import ttad_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_trim;

    // product fits the accumulator for every operand pair used
    assign prod_trim = prod_reg[ACC_W-1:0];

    // accumulator update from the previous product
    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_trim;
            ACC_ADD:  acc_next = acc_reg + prod_trim;
            ACC_SUB:  acc_next = acc_reg - prod_trim;
            default:  acc_next = acc_reg;
        endcase
    end

    // one multiply per cycle, registered
    always_ff @(posedge aclk) begin
        prod_reg <= cmd.op_a * cmd.op_b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

/* test/ttad_sample_checker.sv */
module ttad_sample_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // channel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // sample
    input  logic        m_tuser,   // out_channel
    input  logic        m_tlast,   // last
    output int          pcm_pending,
    output int          mismatch_count
);

    localparam longint PREV_TAP  = 64'sh7298;
    localparam longint OLDER_TAP = 64'sh3350;
    localparam longint PCM_MAX   = 32767;
    localparam longint PCM_MIN   = -32768;
    localparam int     CODE_END  = ttad_pkg::CODE_BYTES + 1;

    typedef struct packed {
        logic        chan;
        logic [15:0] sample;
        logic        last;
    } pcm_word_t;

    pcm_word_t pcm_expected_q[$];

    // decoder state as seen from the byte stream
    logic [15:0]        gain;
    logic [15:0]        frame_scale;
    int                 byte_pos;
    logic signed [15:0] prev_pcm  [ttad_pkg::CHANNELS];
    logic signed [15:0] older_pcm [ttad_pkg::CHANNELS];

    // one nibble through the two-tap predictor, updates that channel's history
    function automatic logic signed [15:0] decode_nibble(input logic ch, input logic [3:0] code);
        longint delta;
        longint acc;
        longint pcm;
        delta = longint'($signed(code));
        acc = longint'(gain) * longint'(frame_scale) * delta
              + PREV_TAP * longint'(prev_pcm[ch])
              - OLDER_TAP * longint'(older_pcm[ch]);
        pcm = acc >>> 14;
        if (pcm > PCM_MAX) begin
            pcm = PCM_MAX;
        end else if (pcm < PCM_MIN) begin
            pcm = PCM_MIN;
        end
        older_pcm[ch] = prev_pcm[ch];
        prev_pcm[ch]  = pcm[15:0];
        return pcm[15:0];
    endfunction

    // scale bytes load the frame scale, code bytes give a sample pair
    task automatic take_byte(input logic ch, input logic [7:0] b);
        pcm_word_t w;
        case (byte_pos)
            0: begin
                frame_scale[15:8] = b;
                byte_pos = 1;
            end
            1: begin
                frame_scale[7:0] = b;
                byte_pos = 2;
            end
            default: begin
                w.chan   = ch;
                w.sample = decode_nibble(ch, b[7:4]);
                w.last   = 1'b0;
                pcm_expected_q.push_back(w);
                w.sample = decode_nibble(ch, b[3:0]);
                w.last   = 1'b1;
                pcm_expected_q.push_back(w);
                byte_pos = (byte_pos >= CODE_END) ? 0 : byte_pos + 1;
            end
        endcase
    endtask

    // compare one output word against the oldest expected sample
    task automatic check_sample();
        pcm_word_t want;
        if (pcm_expected_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word: ch %0d sample %0d last %0d",
                     $time, m_tuser, $signed(m_tdata), m_tlast);
        end else begin
            want = pcm_expected_q.pop_front();
            if (want.chan !== m_tuser || want.sample !== m_tdata || want.last !== m_tlast) begin
                mismatch_count++;
                $display({"%0t: mismatch: expected ch %0d sample %0d last %0d,",
                          " got ch %0d sample %0d last %0d"},
                         $time, want.chan, $signed(want.sample), want.last,
                         m_tuser, $signed(m_tdata), m_tlast);
            end
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        if (!aresetn) begin
            gain        = 16'd16384;
            frame_scale = '0;
            byte_pos    = 0;
            for (int i = 0; i < ttad_pkg::CHANNELS; i++) begin
                prev_pcm[i]  = '0;
                older_pcm[i] = '0;
            end
            pcm_expected_q.delete();
            mismatch_count = 0;
            pcm_pending <= 0;
        end else begin
            if (cfg_we) begin
                gain = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_sample();
            end
            pcm_pending <= pcm_expected_q.size();
        end
    end

endmodule

/* test/tb_two_tap_adpcm_frame_decoder.sv */
module tb_two_tap_adpcm_frame_decoder;

    localparam int FRAME_BYTES = ttad_pkg::CODE_BYTES + 2;
    localparam int SETTLE      = 24;
    localparam int PHASES      = 8;
    localparam int FRAMES      = 10;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int pcm_pending;
    int mismatch_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    int frame_pos = 0;

    two_tap_adpcm_frame_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ttad_sample_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .pcm_pending    (pcm_pending),
        .mismatch_count (mismatch_count)
    );

    always #10 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one byte word on the input channel, with random idle cycles ahead of it
    task automatic send_byte(input logic ch, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_pos = (frame_pos == FRAME_BYTES - 1) ? 0 : frame_pos + 1;
    endtask

    // hold the input until every expected sample has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pcm_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // complete the current frame with random codes
    task automatic fill_frame(input logic ch);
        while (frame_pos != 0) send_byte(ch, 8'($urandom_range(255)));
    endtask

    // whole frame; a mixed frame picks a random channel for every byte
    task automatic send_frame(input logic ch, input logic [15:0] scale, input bit mixed);
        send_byte(mixed ? 1'($urandom_range(1)) : ch, scale[15:8]);
        send_byte(mixed ? 1'($urandom_range(1)) : ch, scale[7:0]);
        for (int i = 0; i < ttad_pkg::CODE_BYTES; i++) begin
            send_byte(mixed ? 1'($urandom_range(1)) : ch, 8'($urandom_range(255)));
        end
    endtask

    // overall time limit
    initial begin
        #40000000;
        $display("two_tap_adpcm_frame_decoder test failed");
        $finish;
    end

    initial begin
        logic [15:0] phase_gain;
        logic [15:0] scale;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gain, unit scale: small codes, flooring of negative sums,
        // extreme codes and a channel change inside the frame
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'hF1);
        send_byte(1'b0, 8'h80);
        send_byte(1'b1, 8'h7F);
        send_byte(1'b0, 8'h0F);
        fill_frame(1'b0);

        // largest gain and scale: full-width products, saturation both ways
        write_gain(16'hFFFF);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'h77);
        send_byte(1'b1, 8'h77);
        send_byte(1'b1, 8'h88);
        send_byte(1'b1, 8'h88);
        send_byte(1'b0, 8'h7F);
        fill_frame(1'b1);

        // random frames across gain settings and handshake pressure
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_gain = 16'd0;
                1:       phase_gain = 16'd1;
                2:       phase_gain = 16'd16384;
                3:       phase_gain = 16'hFFFF;
                default: phase_gain = 16'($urandom_range(16'hFFFF));
            endcase
            write_gain(phase_gain);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int f = 0; f < FRAMES; f++) begin
                if ($urandom_range(3) == 0) begin
                    scale = 16'($urandom_range(16'hFFFF));
                end else begin
                    scale = 16'($urandom_range(4095));
                end
                send_frame(1'($urandom_range(1)), scale, $urandom_range(4) == 0);
                if (p == 2 && f == 4) begin
                    wait_drained();
                end
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();

        if (mismatch_count == 0 && pcm_pending == 0) begin
            $display("two_tap_adpcm_frame_decoder test passed");
        end else begin
            $display("two_tap_adpcm_frame_decoder test failed");
        end
        $finish;
    end

endmodule
